@@ hw/rtl/wrpm_pkg.sv @@
package wrpm_pkg;

  localparam int Window = 20;
  localparam int CntW = $clog2(Window + 1);
  localparam int IdxW = $clog2(Window);
  localparam int SumW = $clog2(Window * 255 + 1);
  localparam int DevW = $clog2(Window * 65025 + 1);
  localparam int GainW = 24;
  localparam int CfgIdxW = 1;
  localparam int QDepth = 2;

  // x / Window as (x * DivMul) >> DivShift; exact for x below 2^22 at Window = 20
  localparam int DivShift = 26;
  localparam int DivMul = ((1 << DivShift) + Window - 1) / Window;

  localparam logic [CfgIdxW-1:0] RegVoltageGain = 1'd0;
  localparam logic [CfgIdxW-1:0] RegCurrentGain = 1'd1;

  localparam logic [GainW-1:0] VoltageGainReset = 24'd41958;
  localparam logic [GainW-1:0] CurrentGainReset = 24'd2097;

  typedef struct packed {
    logic [7:0] current_sample;
    logic [7:0] voltage_sample;
  } in_item_t;

  typedef struct packed {
    logic [31:0] voltage_rms_q16;
    logic [31:0] current_avg_q16;
    logic [47:0] power_q16;
  } out_item_t;

  // Window-end job handed from front to back.
  typedef struct packed {
    logic [SumW-1:0] voltage_sum;
    logic [SumW-1:0] current_sum;
  } job_t;

endpackage

@@ hw/rtl/window_rms_power_meter.sv @@
// Windowed RMS voltage / average current / power meter. One transaction on
// start carries a current and a voltage sample. After 20 pairs one result
// appears on result with done high for a single cycle; the receiver cannot
// stall it, so sample it when done is high. Once a window is complete, busy
// stays high until the math engine has swept the stored voltage samples:
// the job leaves the queue, the two means are formed by reciprocal multiply,
// and the sweep reads every store slot. The result then follows through the
// deviation divide, a 10-step root, gain scaling, the power multiply and the
// output register. Pairs of the next window are taken while these run. Gain
// registers may only be written while no window result is pending.
module window_rms_power_meter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  wrpm_pkg::in_item_t              sample,
  output logic                            done,
  output wrpm_pkg::out_item_t             result,
  input  logic                            cfg_we,
  input  logic [wrpm_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [wrpm_pkg::GainW-1:0]      cfg_data
);
  import wrpm_pkg::*;

  logic [GainW-1:0] voltage_gain, current_gain;
  logic             take;
  logic             store_we;
  logic [IdxW-1:0]  store_addr, rd_addr;
  logic [7:0]       store_data, rd_data;
  logic             job_push, job_pop, q_valid, q_full;
  logic             sweeping;
  job_t             job_in, job_head;

  // hold samples off while a finished window still owns the store
  assign busy = q_full || q_valid || sweeping;
  assign take = start && !busy;

  // gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_gain <= VoltageGainReset;
      current_gain <= CurrentGainReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegVoltageGain: voltage_gain <= cfg_data;
        RegCurrentGain: current_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  wrpm_front u_front (
    .clk, .rst, .take, .item(sample),
    .store_we, .store_addr, .store_data,
    .job_push, .job(job_in)
  );

  // Store holds one window; busy keeps the front from writing it from the
  // end of a window until the back has read every slot.
  wrpm_ram #(.Width(8), .Depth(Window)) u_store (
    .clk, .we(store_we), .waddr(store_addr), .wdata(store_data),
    .raddr(rd_addr), .rdata(rd_data)
  );

  wrpm_queue u_queue (
    .clk, .rst, .push(job_push), .push_data(job_in),
    .pop(job_pop), .not_empty(q_valid), .full(q_full), .head(job_head)
  );

  wrpm_back u_back (
    .clk, .rst, .job_valid(q_valid), .job(job_head), .job_pop, .sweeping,
    .rd_addr, .rd_data, .voltage_gain, .current_gain,
    .done, .result
  );
endmodule

@@ hw/rtl/wrpm_ram.sv @@
module wrpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/wrpm_front.sv @@
module wrpm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  wrpm_pkg::in_item_t item,
  output logic              store_we,
  output logic [wrpm_pkg::IdxW-1:0] store_addr,
  output logic [7:0]        store_data,
  output logic              job_push,
  output wrpm_pkg::job_t    job
);
  import wrpm_pkg::*;

  logic [CntW-1:0] pair_count;
  logic [SumW-1:0] voltage_sum, current_sum;
  logic [SumW-1:0] vs_next, cs_next;
  logic            last;

  assign vs_next = voltage_sum + SumW'(item.voltage_sample);
  assign cs_next = current_sum + SumW'(item.current_sample);
  assign last = (pair_count == CntW'(Window - 1));

  assign store_we = take;
  assign store_addr = pair_count[IdxW-1:0];
  assign store_data = item.voltage_sample;
  assign job_push = take && last;
  assign job.voltage_sum = vs_next;
  assign job.current_sum = cs_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= '0;
      voltage_sum <= '0;
      current_sum <= '0;
    end else if (take) begin
      if (last) begin
        pair_count <= '0;
        voltage_sum <= '0;
        current_sum <= '0;
      end else begin
        pair_count <= pair_count + CntW'(1);
        voltage_sum <= vs_next;
        current_sum <= cs_next;
      end
    end
  end
endmodule

@@ hw/rtl/wrpm_queue.sv @@
module wrpm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wrpm_pkg::job_t push_data,
  input  logic           pop,
  output logic           not_empty,
  output logic           full,
  output wrpm_pkg::job_t head
);
  import wrpm_pkg::*;

  localparam int PtrW = $clog2(QDepth);

  job_t            slots [QDepth];
  logic [PtrW-1:0] rd_ptr, wr_ptr;
  logic [PtrW:0]   fill;

  assign not_empty = (fill != '0);
  assign full = (fill == (PtrW+1)'(QDepth));
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      fill <= fill + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

@@ hw/rtl/wrpm_back.sv @@
module wrpm_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_valid,
  input  wrpm_pkg::job_t            job,
  output logic                      job_pop,
  output logic                      sweeping,
  output logic [wrpm_pkg::IdxW-1:0] rd_addr,
  input  logic [7:0]                rd_data,
  input  logic [wrpm_pkg::GainW-1:0] voltage_gain,
  input  logic [wrpm_pkg::GainW-1:0] current_gain,
  output logic                      done,
  output wrpm_pkg::out_item_t       result
);
  import wrpm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIVV  = 8'b0000_0010,
    S_DEV   = 8'b0000_0100,
    S_DIVD  = 8'b0000_1000,
    S_SQRT  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_POW   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  localparam int RootW = DevW / 2;
  localparam int StepW = $clog2(DevW + 1);

  state_t           state;
  job_t             cur;
  logic [DevW-1:0]  num;       // root radicand, consumed two bits per cycle
  logic [StepW-1:0] step;
  logic [7:0]       v_mean, c_mean;
  logic [IdxW:0]    rd_cnt;
  logic             rd_live;
  logic [DevW-1:0]  dev_acc;
  logic [RootW-1:0] root;
  logic [DevW+1:0]  sq_rem;
  logic [31:0]      v_out, c_out;
  logic [63:0]      prod;

  // divide by Window through a reciprocal multiply
  function automatic logic [DevW-1:0] div_window(logic [DevW-1:0] x);
    logic [DevW+DivShift-1:0] p;
    p = (DevW+DivShift)'(x) * (DevW+DivShift)'(DivMul);
    return p[DevW+DivShift-1:DivShift];
  endfunction

  logic [8:0] diff;
  logic [7:0] absd;
  assign diff = {1'b0, rd_data} - {1'b0, v_mean};
  assign absd = diff[8] ? 8'(-diff) : diff[7:0];

  // non-restoring-free digit recurrence for the root, two bits per cycle
  logic [DevW+1:0] sq_cur;
  logic [DevW+1:0] sq_try;
  assign sq_cur = {sq_rem[DevW-1:0], num[DevW-1 -: 2]};
  assign sq_try = sq_cur - (DevW+2)'({root, 2'b01});

  assign job_pop = (state == S_IDLE) && job_valid;
  assign rd_addr = rd_cnt[IdxW-1:0];
  // store still holds samples the sweep has not read yet
  assign sweeping = (state == S_DIVV) || (state == S_DEV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            state <= S_DIVV;
          end
        end
        S_DIVV: begin
          v_mean <= 8'(div_window(DevW'(cur.voltage_sum)));
          c_mean <= 8'(div_window(DevW'(cur.current_sum)));
          rd_cnt <= '0;
          rd_live <= 1'b0;
          dev_acc <= '0;
          state <= S_DEV;
        end
        S_DEV: begin
          if (rd_live) begin
            dev_acc <= dev_acc + DevW'(absd * absd);
          end
          if (rd_cnt == (IdxW+1)'(Window)) begin
            rd_live <= 1'b0;
            if (!rd_live) begin
              state <= S_DIVD;
            end
          end else begin
            rd_cnt <= rd_cnt + (IdxW+1)'(1);
            rd_live <= 1'b1;
          end
        end
        S_DIVD: begin
          num <= div_window(dev_acc) << (DevW - 2 * RootW);
          sq_rem <= '0;
          root <= '0;
          step <= StepW'(RootW);
          state <= S_SQRT;
        end
        S_SQRT: begin
          num <= num << 2;
          if (!sq_try[DevW+1]) begin
            sq_rem <= sq_try;
            root <= {root[RootW-2:0], 1'b1};
          end else begin
            sq_rem <= sq_cur;
            root <= {root[RootW-2:0], 1'b0};
          end
          step <= step - StepW'(1);
          if (step == StepW'(1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          v_out <= 32'(root * voltage_gain);
          c_out <= 32'(c_mean * current_gain);
          state <= S_POW;
        end
        S_POW: begin
          prod <= v_out * c_out;
          state <= S_OUT;
        end
        S_OUT: begin
          result.voltage_rms_q16 <= v_out;
          result.current_avg_q16 <= c_out;
          result.power_q16 <= prod[63:16];
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/wrpm_checker.sv @@
module wrpm_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !done && !busy) else $error("activity right after reset");
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(!rst, 2)) else $error("result too soon");
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({start, busy, done})) else $error("control signal unknown");
endmodule

bind window_rms_power_meter wrpm_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
